>>> design/bts_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the bilinear texture sampler
package bts_pkg;

   localparam int STORE_DEPTH  = 65536;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
   localparam int TEXEL_W      = 64;
   localparam int MAX_DIM      = 4096;
   localparam int DIM_W        = 13;
   localparam int POS_W        = $clog2(MAX_DIM);
   localparam int IDX_W        = 2 * POS_W;
   localparam int COORD_W      = 16;
   localparam int LANE_W       = 16;
   localparam int BYTE_W       = 8;
   localparam int CH_N         = 4;
   localparam int TAP_N        = 4;
   localparam int STEP_W       = $clog2(TAP_N);
   localparam int OUT_W        = 25;
   localparam int FMT_W        = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_TEX_WIDTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEX_HEIGHT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_FORMAT = 2'd2;

   localparam logic [FMT_W-1:0] FMT_8BIT  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_16BIT = 2'd1;

   localparam logic [COORD_W:0] COORD_ONE = 17'h10000;

   typedef logic [CH_N-1:0][OUT_W-1:0] pixel_type;

   typedef struct packed {
      logic                             valid;
      logic [TAP_N-1:0][TEXEL_W-1:0]    texel;
      logic [COORD_W-1:0]               wx;
      logic [COORD_W-1:0]               wy;
   } blend_req_type;

   typedef struct packed {
      logic      valid;
      pixel_type chan;
   } blend_rsp_type;

endpackage

>>> design/bts_ram.sv
`timescale 1ns / 1ps
// generic single-clock ram with one write port and one registered read port
module bts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/bts_blend.sv
`timescale 1ns / 1ps
// four-stage blend pipeline: horizontal lerp, vertical lerp, rounded divide by 255
module bts_blend (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bts_pkg::FMT_W-1:0]  format,
   input  bts_pkg::blend_req_type     blend_in,
   output bts_pkg::blend_rsp_type     blend_out
);
   import bts_pkg::*;

   localparam int TOP_W   = LANE_W + COORD_W;
   localparam int BLEND_W = TOP_W + COORD_W;
   localparam int X_W     = BLEND_W + 1;
   localparam int Y_W     = X_W - COORD_W;
   localparam int YH_W    = Y_W - COORD_W;
   localparam int Z_W     = YH_W + 1;
   localparam int ZH_W    = Z_W - BYTE_W;
   localparam int T_W     = ZH_W + 1;
   localparam int Q_W     = OUT_W + 1;
   localparam logic [X_W-1:0]    ROUND_BIAS = X_W'(255) << (COORD_W - 1);
   localparam logic [BYTE_W:0]   DIGIT_MAX  = 9'd255;

   function automatic logic [LANE_W-1:0] get_lane(
      input logic [TEXEL_W-1:0] word,
      input int                 ch,
      input logic [FMT_W-1:0]   fmt
   );
      logic [LANE_W-1:0] v;
      v = word[ch*LANE_W +: LANE_W];
      if (fmt == FMT_8BIT) begin
         v = {{(LANE_W-BYTE_W){1'b0}}, v[BYTE_W-1:0]};
      end
      return v;
   endfunction

   // stage a: horizontal lerp
   logic                        a_valid_ff;
   logic [CH_N-1:0][TOP_W-1:0]  a_top_ff, a_top_in;
   logic [CH_N-1:0][TOP_W-1:0]  a_bot_ff, a_bot_in;
   logic [COORD_W-1:0]          a_wy_ff;
   logic [COORD_W:0]            wxc;

   always_comb begin
      wxc = COORD_ONE - {1'b0, blend_in.wx};
      for (int c = 0; c < CH_N; c++) begin
         a_top_in[c] = TOP_W'(get_lane(blend_in.texel[0], c, format)) * TOP_W'(wxc)
                     + TOP_W'(get_lane(blend_in.texel[1], c, format)) * TOP_W'(blend_in.wx);
         a_bot_in[c] = TOP_W'(get_lane(blend_in.texel[2], c, format)) * TOP_W'(wxc)
                     + TOP_W'(get_lane(blend_in.texel[3], c, format)) * TOP_W'(blend_in.wx);
      end
   end

   // stage b: vertical lerp
   logic                          b_valid_ff;
   logic [CH_N-1:0][BLEND_W-1:0]  b_blend_ff, b_blend_in;
   logic [COORD_W:0]              wyc;

   always_comb begin
      wyc = COORD_ONE - {1'b0, a_wy_ff};
      for (int c = 0; c < CH_N; c++) begin
         b_blend_in[c] = BLEND_W'(a_top_ff[c]) * BLEND_W'(wyc)
                       + BLEND_W'(a_bot_ff[c]) * BLEND_W'(a_wy_ff);
      end
   end

   // stage c: rounding bias, fold the upper base-65536 digit
   logic                       c_valid_ff;
   logic [CH_N-1:0][YH_W-1:0]  c_yh_ff, c_yh_in;
   logic [CH_N-1:0][Z_W-1:0]   c_z_ff, c_z_in;
   logic [X_W-1:0]             x_sum [CH_N];
   logic [Y_W-1:0]             y_val [CH_N];

   always_comb begin
      for (int c = 0; c < CH_N; c++) begin
         x_sum[c]   = X_W'(b_blend_ff[c]) + ROUND_BIAS;
         y_val[c]   = x_sum[c][X_W-1:COORD_W];
         c_yh_in[c] = y_val[c][Y_W-1:COORD_W];
         c_z_in[c]  = Z_W'(y_val[c][Y_W-1:COORD_W]) + Z_W'(y_val[c][COORD_W-1:0]);
      end
   end

   // stage d: fold base-256 digits and finish the quotient
   logic                 d_valid_ff;
   pixel_type            d_chan_ff, d_chan_in;
   logic [T_W-1:0]       t_sum [CH_N];
   logic [BYTE_W:0]      t2_sum [CH_N];
   logic [Q_W-1:0]       q_val [CH_N];

   always_comb begin
      for (int c = 0; c < CH_N; c++) begin
         t_sum[c]  = T_W'(c_z_ff[c][Z_W-1:BYTE_W]) + T_W'(c_z_ff[c][BYTE_W-1:0]);
         t2_sum[c] = (BYTE_W+1)'(t_sum[c][T_W-1:BYTE_W]) + (BYTE_W+1)'(t_sum[c][BYTE_W-1:0]);
         q_val[c]  = (Q_W'(c_yh_ff[c]) << BYTE_W) + Q_W'(c_yh_ff[c])
                   + Q_W'(c_z_ff[c][Z_W-1:BYTE_W])
                   + Q_W'(t_sum[c][T_W-1:BYTE_W])
                   + Q_W'(t2_sum[c] >= DIGIT_MAX);
         if (format != FMT_8BIT && format != FMT_16BIT) begin
            d_chan_in[c] = '0;
         end else begin
            d_chan_in[c] = q_val[c][OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= blend_in.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_top_ff   <= a_top_in;
      a_bot_ff   <= a_bot_in;
      a_wy_ff    <= blend_in.wy;
      b_blend_ff <= b_blend_in;
      c_yh_ff    <= c_yh_in;
      c_z_ff     <= c_z_in;
      d_chan_ff  <= d_chan_in;
   end

   assign blend_out.valid = d_valid_ff;
   assign blend_out.chan  = d_chan_ff;

   // every request passes stage registers a, b, c and d and leaves; none is lost
   assert property (@(posedge clock) disable iff (reset)
      blend_in.valid |-> ##4 blend_out.valid)
      else $error("blend pipeline lost a request");

   assert property (@(posedge clock) disable iff (reset)
      blend_out.valid |-> $past(blend_in.valid, 4))
      else $error("blend pipeline produced a result without a request");

   assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && format != FMT_8BIT && format != FMT_16BIT |=> d_chan_ff == '0)
      else $error("unsupported format did not give zeros");

endmodule

>>> design/bilinear_texture_sampler_top.sv
`timescale 1ns / 1ps
// top level of the bilinear texture sampler
//
// A write request stores one 64-bit RGBA texel at its row-major address and
// gives no response; a sample request gives one response of four filtered
// channels, each the bilinear blend divided by 255 with 16 fraction bits.
// The texel store is one memory with one write port and one registered read
// port, used for one access at a time: a sample reads it once per neighbouring
// texel and a write takes a single access, so the store takes one write per
// cycle while no sample holds the sequencer. Up to 4 responses are buffered;
// the block keeps taking requests while responses wait and holds back when a
// further sample would find no free response slot or the sequencer is busy.
// Texels must be written before they are sampled; the store has no reset and
// no clearing pass. Configuration registers may only be changed while no
// request is in flight.
module bilinear_texture_sampler_top (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [bts_pkg::STORE_ADDR_W-1:0] req_write_address,
   input  logic [bts_pkg::TEXEL_W-1:0]      req_texel_word,
   input  logic [bts_pkg::COORD_W-1:0]      req_u_coord,
   input  logic [bts_pkg::COORD_W-1:0]      req_v_coord,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bts_pkg::OUT_W-1:0]        rsp_red,
   output logic [bts_pkg::OUT_W-1:0]        rsp_green,
   output logic [bts_pkg::OUT_W-1:0]        rsp_blue,
   output logic [bts_pkg::OUT_W-1:0]        rsp_alpha,

   input  logic                             csr_write_enable,
   input  logic [bts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bts_pkg::*;

   localparam int SU_W = COORD_W + DIM_W;
   localparam int SV_W = COORD_W + 1 + DIM_W;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TAP_N - 1);

   // configuration registers
   logic [DIM_W-1:0] tex_width_ff;
   logic [DIM_W-1:0] tex_height_ff;
   logic [FMT_W-1:0] format_ff;
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= DIM_W'(1);
         tex_height_ff <= DIM_W'(1);
         format_ff     <= FMT_8BIT;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TEX_WIDTH:      tex_width_ff  <= csr_write_data[DIM_W-1:0];
            REG_TEX_HEIGHT:     tex_height_ff <= csr_write_data[DIM_W-1:0];
            REG_CHANNEL_FORMAT: format_ff     <= csr_write_data[FMT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (tex_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (tex_width_ff > DIM_W'(MAX_DIM)) begin
         w_eff = DIM_W'(MAX_DIM);
      end else begin
         w_eff = tex_width_ff;
      end
      if (tex_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (tex_height_ff > DIM_W'(MAX_DIM)) begin
         h_eff = DIM_W'(MAX_DIM);
      end else begin
         h_eff = tex_height_ff;
      end
   end

   // pipeline handshake
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic p1_valid_in, p2_valid_in, p3_valid_in;
   logic p1_take, p2_take, p3_take;
   logic p2_ready, p3_ready;
   logic seq_take;

   assign p3_ready  = !p3_valid_ff || seq_take;
   assign p2_ready  = !p2_valid_ff || p3_take;
   assign req_ready = !p1_valid_ff || p2_take;
   assign p1_take   = req_valid && req_ready;
   assign p2_take   = p1_valid_ff && p2_ready;
   assign p3_take   = p2_valid_ff && p3_ready;

   assign p1_valid_in = p1_take || (p1_valid_ff && !p2_take);
   assign p2_valid_in = p2_take || (p2_valid_ff && !p3_take);
   assign p3_valid_in = p3_take || (p3_valid_ff && !seq_take);

   // stage 1: flip v and scale coordinates by the texture size
   logic                    p1_op_ff;
   logic [STORE_ADDR_W-1:0] p1_waddr_ff;
   logic [TEXEL_W-1:0]      p1_word_ff;
   logic [SU_W-1:0]         p1_su_ff, p1_su_in;
   logic [SV_W-1:0]         p1_sv_ff, p1_sv_in;
   logic [COORD_W:0]        v_flip;

   always_comb begin
      v_flip   = COORD_ONE - {1'b0, req_v_coord};
      p1_su_in = SU_W'(req_u_coord) * SU_W'(w_eff);
      p1_sv_in = SV_W'(v_flip) * SV_W'(h_eff);
   end

   // stage 2: clamp texel positions, keep fractions as weights
   logic                    p2_op_ff;
   logic [STORE_ADDR_W-1:0] p2_waddr_ff;
   logic [TEXEL_W-1:0]      p2_word_ff;
   logic [POS_W-1:0]        p2_x0_ff, p2_x0_in;
   logic [POS_W-1:0]        p2_x1_ff, p2_x1_in;
   logic [POS_W-1:0]        p2_y0_ff, p2_y0_in;
   logic [POS_W-1:0]        p2_y1_ff, p2_y1_in;
   logic [COORD_W-1:0]      p2_wx_ff;
   logic [COORD_W-1:0]      p2_wy_ff;
   logic [DIM_W-1:0]        fu, wm1, fx;
   logic [DIM_W:0]          fv, hm1, fy;

   always_comb begin
      fu  = p1_su_ff[SU_W-1:COORD_W];
      wm1 = w_eff - DIM_W'(1);
      fx  = (fu > wm1) ? wm1 : fu;
      p2_x0_in = fx[POS_W-1:0];
      p2_x1_in = (fx == wm1) ? wm1[POS_W-1:0] : fx[POS_W-1:0] + POS_W'(1);
      fv  = p1_sv_ff[SV_W-1:COORD_W];
      hm1 = {1'b0, h_eff - DIM_W'(1)};
      fy  = (fv > hm1) ? hm1 : fv;
      p2_y0_in = fy[POS_W-1:0];
      p2_y1_in = (fy == hm1) ? hm1[POS_W-1:0] : fy[POS_W-1:0] + POS_W'(1);
   end

   // stage 3: row base addresses
   logic                    p3_op_ff;
   logic [STORE_ADDR_W-1:0] p3_waddr_ff;
   logic [TEXEL_W-1:0]      p3_word_ff;
   logic [IDX_W-1:0]        p3_row0_ff, p3_row0_in;
   logic [IDX_W-1:0]        p3_row1_ff, p3_row1_in;
   logic [POS_W-1:0]        p3_x0_ff, p3_x1_ff;
   logic [COORD_W-1:0]      p3_wx_ff, p3_wy_ff;

   assign p3_row0_in = IDX_W'(w_eff) * IDX_W'(p2_y0_ff);
   assign p3_row1_in = IDX_W'(w_eff) * IDX_W'(p2_y1_ff);

   always_ff @(posedge clock) begin
      if (p1_take) begin
         p1_op_ff    <= req_opcode;
         p1_waddr_ff <= req_write_address;
         p1_word_ff  <= req_texel_word;
         p1_su_ff    <= p1_su_in;
         p1_sv_ff    <= p1_sv_in;
      end
      if (p2_take) begin
         p2_op_ff    <= p1_op_ff;
         p2_waddr_ff <= p1_waddr_ff;
         p2_word_ff  <= p1_word_ff;
         p2_x0_ff    <= p2_x0_in;
         p2_x1_ff    <= p2_x1_in;
         p2_y0_ff    <= p2_y0_in;
         p2_y1_ff    <= p2_y1_in;
         p2_wx_ff    <= p1_su_ff[COORD_W-1:0];
         p2_wy_ff    <= p1_sv_ff[COORD_W-1:0];
      end
      if (p3_take) begin
         p3_op_ff    <= p2_op_ff;
         p3_waddr_ff <= p2_waddr_ff;
         p3_word_ff  <= p2_word_ff;
         p3_row0_ff  <= p3_row0_in;
         p3_row1_ff  <= p3_row1_in;
         p3_x0_ff    <= p2_x0_ff;
         p3_x1_ff    <= p2_x1_ff;
         p3_wx_ff    <= p2_wx_ff;
         p3_wy_ff    <= p2_wy_ff;
      end
   end

   // memory sequencer: one write, or four texel reads per sample
   logic                    seq_valid_ff, seq_valid_in;
   logic [STEP_W-1:0]       seq_step_ff, seq_step_in;
   logic                    seq_op_ff;
   logic [STORE_ADDR_W-1:0] seq_waddr_ff;
   logic [TEXEL_W-1:0]      seq_word_ff;
   logic [IDX_W-1:0]        seq_row0_ff, seq_row1_ff;
   logic [POS_W-1:0]        seq_x0_ff, seq_x1_ff;
   logic [COORD_W-1:0]      seq_wx_ff, seq_wy_ff;
   logic                    seq_last;
   logic                    seq_free;
   logic [IDX_W-1:0]        seq_index;
   logic                    seq_oob;
   logic [CNT_W-1:0]        credit_ff, credit_in;
   logic                    credit_ok;
   logic                    rsp_pop;

   assign seq_last  = (seq_op_ff == OP_WRITE) || (seq_step_ff == LAST_STEP);
   assign seq_free  = !seq_valid_ff || seq_last;
   assign credit_ok = credit_ff != CNT_W'(FIFO_DEPTH);
   assign seq_take  = p3_valid_ff && seq_free && (p3_op_ff == OP_WRITE || credit_ok);

   always_comb begin
      seq_index = (seq_step_ff[1] ? seq_row1_ff : seq_row0_ff)
                + IDX_W'(seq_step_ff[0] ? seq_x1_ff : seq_x0_ff);
      seq_oob   = seq_index[IDX_W-1:STORE_ADDR_W] != '0;
      if (seq_take) begin
         seq_valid_in = 1'b1;
         seq_step_in  = '0;
      end else begin
         seq_valid_in = seq_valid_ff && !seq_last;
         seq_step_in  = seq_step_ff + STEP_W'(1);
      end
      credit_in = credit_ff + CNT_W'(seq_take && p3_op_ff == OP_SAMPLE) - CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (seq_take) begin
         seq_op_ff    <= p3_op_ff;
         seq_waddr_ff <= p3_waddr_ff;
         seq_word_ff  <= p3_word_ff;
         seq_row0_ff  <= p3_row0_ff;
         seq_row1_ff  <= p3_row1_ff;
         seq_x0_ff    <= p3_x0_ff;
         seq_x1_ff    <= p3_x1_ff;
         seq_wx_ff    <= p3_wx_ff;
         seq_wy_ff    <= p3_wy_ff;
      end
      seq_step_ff <= seq_step_in;
   end

   // texel store
   logic                ram_we, ram_re;
   logic [TEXEL_W-1:0]  ram_rdata;

   assign ram_we = seq_valid_ff && seq_op_ff == OP_WRITE;
   assign ram_re = seq_valid_ff && seq_op_ff == OP_SAMPLE;

   bts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_texel_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (seq_waddr_ff),
      .wdata (seq_word_ff),
      .re    (ram_re),
      .raddr (seq_index[STORE_ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   // read return and texel gather
   logic                rd_valid_ff;
   logic [STEP_W-1:0]   rd_step_ff;
   logic                rd_oob_ff;
   logic [COORD_W-1:0]  rd_wx_ff, rd_wy_ff;
   logic [TEXEL_W-1:0]  rd_texel;
   logic [TEXEL_W-1:0]  gather_ff [TAP_N];

   assign rd_texel = rd_oob_ff ? '0 : ram_rdata;

   always_ff @(posedge clock) begin
      rd_step_ff <= seq_step_ff;
      rd_oob_ff  <= seq_oob;
      rd_wx_ff   <= seq_wx_ff;
      rd_wy_ff   <= seq_wy_ff;
      if (rd_valid_ff && rd_step_ff != LAST_STEP) begin
         gather_ff[rd_step_ff] <= rd_texel;
      end
   end

   blend_req_type blend_in;
   blend_rsp_type blend_out;

   always_comb begin
      blend_in.valid    = rd_valid_ff && rd_step_ff == LAST_STEP;
      blend_in.texel[0] = gather_ff[0];
      blend_in.texel[1] = gather_ff[1];
      blend_in.texel[2] = gather_ff[2];
      blend_in.texel[3] = rd_texel;
      blend_in.wx       = rd_wx_ff;
      blend_in.wy       = rd_wy_ff;
   end

   bts_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .format    (format_ff),
      .blend_in  (blend_in),
      .blend_out (blend_out)
   );

   // response buffer
   pixel_type             fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      fifo_cnt_ff, fifo_cnt_in;
   logic                  fifo_push;

   assign fifo_push   = blend_out.valid;
   assign rsp_valid   = fifo_cnt_ff != '0;
   assign rsp_pop     = rsp_valid && rsp_ready;
   assign fifo_cnt_in = fifo_cnt_ff + CNT_W'(fifo_push) - CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= blend_out.chan;
      end
   end

   assign rsp_red   = fifo_ff[rd_ptr_ff][0];
   assign rsp_green = fifo_ff[rd_ptr_ff][1];
   assign rsp_blue  = fifo_ff[rd_ptr_ff][2];
   assign rsp_alpha = fifo_ff[rd_ptr_ff][3];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         seq_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         credit_ff    <= '0;
         fifo_cnt_ff  <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         p3_valid_ff  <= p3_valid_in;
         seq_valid_ff <= seq_valid_in;
         rd_valid_ff  <= ram_re;
         credit_ff    <= credit_in;
         fifo_cnt_ff  <= fifo_cnt_in;
         wr_ptr_ff    <= wr_ptr_ff + FIFO_PTR_W'(fifo_push);
         rd_ptr_ff    <= rd_ptr_ff + FIFO_PTR_W'(rsp_pop);
      end
   end

   // a finished sample always finds a reserved slot in the response buffer
   assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> credit_ff > fifo_cnt_ff)
      else $error("sample result without a reserved response slot");

   assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> fifo_cnt_ff != CNT_W'(FIFO_DEPTH) || rsp_pop)
      else $error("response buffer overflow");

   assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(FIFO_DEPTH) && credit_ff >= fifo_cnt_ff)
      else $error("response credit out of range");

   // the four texel reads of a sample come in consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && rd_step_ff != LAST_STEP
         |=> rd_valid_ff && rd_step_ff == $past(rd_step_ff) + STEP_W'(1))
      else $error("texel read sequence broken");

   assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("texel store write and read in the same cycle");

endmodule

>>> tb/bilinear_texture_sampler_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench: texel writes and bilinear samples checked against a predictor
module bilinear_texture_sampler_top_tb;
   import bts_pkg::*;

   localparam int CLOCK_HALF_NS = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int STEADY_ITEMS  = 240;
   localparam int RUN_LIMIT_NS  = 20_000_000;

   localparam logic [FMT_W-1:0] FMT_UNSUPPORTED    = 2'd2;
   localparam logic [FMT_W-1:0] FMT_UNSUPPORTED_HI = 2'd3;

   localparam longint unsigned BLEND_ONE    = 64'd65536;
   localparam longint unsigned UNIT_DIVISOR = 64'd255 << COORD_W;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
      logic [OUT_W-1:0] alpha;
   } filtered_pixel_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_opcode = OP_WRITE;
   logic [STORE_ADDR_W-1:0] req_write_address = '0;
   logic [TEXEL_W-1:0]      req_texel_word = '0;
   logic [COORD_W-1:0]      req_u_coord = '0;
   logic [COORD_W-1:0]      req_v_coord = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [OUT_W-1:0]        rsp_red;
   logic [OUT_W-1:0]        rsp_green;
   logic [OUT_W-1:0]        rsp_blue;
   logic [OUT_W-1:0]        rsp_alpha;

   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   // predictor state
   logic [TEXEL_W-1:0] texel_mirror [STORE_DEPTH];
   bit                 texel_written [STORE_DEPTH];
   logic [DIM_W-1:0]   tex_width_reg = 13'd1;
   logic [DIM_W-1:0]   tex_height_reg = 13'd1;
   logic [FMT_W-1:0]   channel_format_reg = FMT_8BIT;

   filtered_pixel_type expected_pixels [$];
   int                 error_count = 0;
   bit                 idle_enable = 1'b1;
   bit                 sink_hold_request = 1'b0;

   bilinear_texture_sampler_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_write_address (req_write_address),
      .req_texel_word    (req_texel_word),
      .req_u_coord       (req_u_coord),
      .req_v_coord       (req_v_coord),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin : clock_gen
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   function automatic int unsigned eff_size(input logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return 32'(d);
   endfunction

   function automatic void split_axis(input int unsigned c, input int unsigned size,
                                      output int unsigned i0, output int unsigned i1,
                                      output int unsigned wt);
      int unsigned s;
      s = c * size;
      i0 = s >> COORD_W;
      wt = s & 32'hffff;
      if (i0 > size - 1) i0 = size - 1;
      i1 = (i0 + 1 > size - 1) ? size - 1 : i0 + 1;
   endfunction

   // tap order: top left, top right, bottom left, bottom right
   function automatic void locate_taps(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                       output logic [TAP_N-1:0][IDX_W-1:0] addr,
                                       output int unsigned wx, output int unsigned wy);
      int unsigned w, h, x0, x1, y0, y1, flipped;
      w = eff_size(tex_width_reg);
      h = eff_size(tex_height_reg);
      flipped = 32'(COORD_ONE) - 32'(v);
      split_axis(32'(u), w, x0, x1, wx);
      split_axis(flipped, h, y0, y1, wy);
      addr[0] = IDX_W'(w * y0 + x0);
      addr[1] = IDX_W'(w * y0 + x1);
      addr[2] = IDX_W'(w * y1 + x0);
      addr[3] = IDX_W'(w * y1 + x1);
   endfunction

   function automatic filtered_pixel_type predict_pixel(input logic [COORD_W-1:0] u,
                                                        input logic [COORD_W-1:0] v);
      logic [TAP_N-1:0][IDX_W-1:0] addr;
      logic [TEXEL_W-1:0]          word [TAP_N];
      longint unsigned             lv [TAP_N];
      longint unsigned             wx, wy, top, bot, blend;
      int unsigned                 wxi, wyi;
      logic [CH_N-1:0][OUT_W-1:0]  chan;
      filtered_pixel_type          px;
      px = '0;
      if (channel_format_reg != FMT_8BIT && channel_format_reg != FMT_16BIT) return px;
      locate_taps(u, v, addr, wxi, wyi);
      wx = 64'(wxi);
      wy = 64'(wyi);
      for (int t = 0; t < TAP_N; t++) begin
         // taps beyond the store read as zero
         word[t] = (addr[t] < STORE_DEPTH) ? texel_mirror[addr[t][STORE_ADDR_W-1:0]] : '0;
      end
      for (int ch = 0; ch < CH_N; ch++) begin
         for (int t = 0; t < TAP_N; t++) begin
            lv[t] = 64'(word[t][LANE_W*ch +: LANE_W]);
            if (channel_format_reg == FMT_8BIT) lv[t] = lv[t] & 64'hff;
         end
         top = lv[0] * (BLEND_ONE - wx) + lv[1] * wx;
         bot = lv[2] * (BLEND_ONE - wx) + lv[3] * wx;
         blend = top * (BLEND_ONE - wy) + bot * wy;
         chan[ch] = OUT_W'((blend + UNIT_DIVISOR / 2) / UNIT_DIVISOR);
      end
      px.red = chan[0];
      px.green = chan[1];
      px.blue = chan[2];
      px.alpha = chan[3];
      return px;
   endfunction

   function automatic logic [TEXEL_W-1:0] any_texel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] any_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] extreme_dim();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 13'd1;
         2: return DIM_W'(MAX_DIM);
         default: return '1;
      endcase
   endfunction

   function automatic logic [FMT_W-1:0] random_format();
      case ($urandom_range(0, 19))
         0: return FMT_UNSUPPORTED;
         1: return FMT_UNSUPPORTED_HI;
         default: return ($urandom_range(0, 1) == 0) ? FMT_8BIT : FMT_16BIT;
      endcase
   endfunction

   // called in step with the rising clock; returns as soon as the design has taken the request
   task automatic send_request(input logic op, input logic [STORE_ADDR_W-1:0] addr,
                               input logic [TEXEL_W-1:0] word,
                               input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      int gap;
      gap = (idle_enable && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_write_address <= addr;
      req_texel_word <= word;
      req_u_coord <= u;
      req_v_coord <= v;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (op == OP_WRITE) begin
         texel_mirror[addr] = word;
         texel_written[addr] = 1'b1;
      end else begin
         expected_pixels.push_back(predict_pixel(u, v));
      end
   endtask

   task automatic write_texel(input logic [STORE_ADDR_W-1:0] addr,
                              input logic [TEXEL_W-1:0] word);
      send_request(OP_WRITE, addr, word, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   // any tap within the store that the sample will read is written first if it is not yet written
   task automatic sample_texture(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
      logic [TAP_N-1:0][IDX_W-1:0] addr;
      int unsigned                 wx, wy;
      locate_taps(u, v, addr, wx, wy);
      for (int t = 0; t < TAP_N; t++) begin
         if (addr[t] < STORE_DEPTH && !texel_written[addr[t][STORE_ADDR_W-1:0]])
            write_texel(addr[t][STORE_ADDR_W-1:0], any_texel());
      end
      send_request(OP_SAMPLE, STORE_ADDR_W'($urandom), {$urandom, $urandom}, u, v);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                            input logic [FMT_W-1:0] fmt);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= REG_TEX_WIDTH;
      csr_write_data <= width;
      @(posedge clock);
      csr_index <= REG_TEX_HEIGHT;
      csr_write_data <= height;
      @(posedge clock);
      csr_index <= REG_CHANNEL_FORMAT;
      csr_write_data <= CSR_DATA_W'(fmt);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tex_width_reg = width;
      tex_height_reg = height;
      channel_format_reg = fmt;
   endtask

   task automatic run_mixed_requests(input int count);
      int unsigned region;
      region = eff_size(tex_width_reg) * eff_size(tex_height_reg);
      if (region > STORE_DEPTH) region = STORE_DEPTH;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0)
               write_texel(STORE_ADDR_W'($urandom_range(0, region - 1)), any_texel());
            else
               write_texel(STORE_ADDR_W'($urandom), any_texel());
         end else begin
            sample_texture(any_coord(), any_coord());
         end
      end
   endtask

   task automatic test_corner_coords();
      configure(13'd2, 13'd2, FMT_16BIT);
      write_texel(16'd0, '1);
      write_texel(16'd1, '0);
      write_texel(16'd2, 64'h0123_4567_89ab_cdef);
      write_texel(16'd3, 64'hffff_0000_8001_7ffe);
      // v of zero flips to one and clamps to the last row
      sample_texture(16'h0000, 16'h0000);
      sample_texture(16'hffff, 16'hffff);
      sample_texture(16'h0000, 16'hffff);
      sample_texture(16'hffff, 16'h0000);
      sample_texture(16'h8000, 16'h8000);
   endtask

   task automatic test_channel_formats();
      configure(13'd2, 13'd2, FMT_8BIT);
      sample_texture(16'h4000, 16'hc000);
      sample_texture(16'h8001, 16'h0001);
      configure(13'd2, 13'd2, FMT_UNSUPPORTED);
      sample_texture(16'h1234, 16'h5678);
      configure(13'd2, 13'd2, FMT_UNSUPPORTED_HI);
      sample_texture(16'hffff, 16'hffff);
   endtask

   task automatic test_size_limits();
      configure(13'd0, 13'd0, FMT_16BIT);
      sample_texture(16'h8000, 16'h8000);
      configure(13'h1fff, 13'h1fff, FMT_16BIT);
      sample_texture(16'h0000, 16'hffff);
      // all four taps of the bottom right corner lie beyond the store
      sample_texture(16'hffff, 16'h0001);
   endtask

   task automatic test_response_backpressure();
      idle_enable = 1'b0;
      configure(13'd8, 13'd8, FMT_16BIT);
      for (int a = 0; a < 64; a++) write_texel(STORE_ADDR_W'(a), any_texel());
      sink_hold_request = 1'b1;
      repeat (48) sample_texture(any_coord(), any_coord());
      idle_enable = 1'b1;
   endtask

   task automatic test_random_textures();
      int               done_items;
      int               count;
      logic [DIM_W-1:0] w, h;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               w = DIM_W'($urandom_range(1, 16));
               h = DIM_W'($urandom_range(1, 16));
               count = 80;
            end
            6, 7: begin
               w = DIM_W'($urandom_range(17, 300));
               h = DIM_W'($urandom_range(1, 200));
               count = 60;
            end
            8: begin
               w = extreme_dim();
               h = extreme_dim();
               count = 30;
            end
            default: begin
               w = DIM_W'($urandom);
               h = DIM_W'($urandom);
               count = 30;
            end
         endcase
         configure(w, h, random_format());
         run_mixed_requests(count);
         done_items += count;
      end
   endtask

   task automatic test_steady_stream();
      idle_enable = 1'b0;
      configure(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 16)),
                ($urandom_range(0, 1) == 0) ? FMT_8BIT : FMT_16BIT);
      run_mixed_requests(STEADY_ITEMS);
   endtask

   task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : response_check
      filtered_pixel_type want;
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected response red %0d green %0d blue %0d alpha %0d",
                   rsp_red, rsp_green, rsp_blue, rsp_alpha);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("alpha", want.alpha, rsp_alpha);
         end
      end
   end

   initial begin : response_sink
      int stall;
      forever begin
         @(posedge clock);
         if (sink_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            sink_hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 11) == 0) begin
            stall = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #RUN_LIMIT_NS;
      $display("bilinear_texture_sampler_top_tb failed");
      $finish;
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_coords();
      test_channel_formats();
      test_size_limits();
      test_response_backpressure();
      test_random_textures();
      test_steady_stream();
      wait_idle();
      if (error_count == 0) begin
         $display("bilinear_texture_sampler_top_tb passed");
      end else begin
         $display("bilinear_texture_sampler_top_tb failed");
      end
      $finish;
   end

endmodule
